FILE: sv/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants of the matrix-vector multiply unit.
// ----------------------------------------------------------------------------
package mvm_pkg;

  localparam int unsigned MAX_COLUMNS_DEF = 1024;
  localparam int unsigned DATA_BITS_DEF   = 16;

  localparam int unsigned ACC_W      = 48;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned CCOUNT_W   = 11;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned OUT_W      = ACC_W + ROW_W;

  localparam logic [CFG_ADDR_W-1:0] CFG_COLUMN_COUNT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW_COUNT    = 1'b1;

  localparam logic [CCOUNT_W-1:0] COLUMN_COUNT_RST = 11'd1024;
  localparam logic [ROW_W-1:0]    ROW_COUNT_RST    = 16'd1024;

  localparam logic MODE_VECTOR = 1'b0;
  localparam logic MODE_MATRIX = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_ACC  = 3'b100
  } state_e;

  typedef struct packed {
    logic vec_load;
    logic mat_start;
    logic mul;
    logic acc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic row_end;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: sv/mvm_ctrl.sv
// ----------------------------------------------------------------------------
// mvm_ctrl
// Sequencer for one beat at a time: accept, multiply, accumulate.
// ----------------------------------------------------------------------------
module mvm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_mode_i,
  output logic                   in_ready_o,
  input  mvm_pkg::dp_status_t    status_i,
  output mvm_pkg::ctrl_cmd_t     cmd_o
);

  mvm_pkg::state_e state_q, state_d;
  logic            accept;

  assign in_ready_o = (state_q == mvm_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.vec_load    = accept && (in_mode_i == mvm_pkg::MODE_VECTOR);
    cmd_o.mat_start   = accept && (in_mode_i == mvm_pkg::MODE_MATRIX);
    case (state_q)
      mvm_pkg::ST_IDLE: begin
        if (cmd_o.mat_start) begin
          state_d = mvm_pkg::ST_MUL;
        end
      end
      mvm_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = mvm_pkg::ST_ACC;
      end
      mvm_pkg::ST_ACC: begin
        if (!(status_i.row_end && status_i.out_busy)) begin
          cmd_o.acc = 1'b1;
          state_d   = mvm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mvm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mvm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/mvm_datapath.sv
// ----------------------------------------------------------------------------
// mvm_datapath
// Vector store, position counters, multiplier, accumulator and output register.
// ----------------------------------------------------------------------------
module mvm_datapath #(
  parameter int unsigned MAX_COLUMNS = mvm_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned DATA_BITS   = mvm_pkg::DATA_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mvm_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic signed [DATA_BITS-1:0]       in_value_i,
  input  mvm_pkg::ctrl_cmd_t                cmd_i,
  output mvm_pkg::dp_status_t               status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mvm_pkg::ACC_W-1:0]  out_sum_o,
  output logic [mvm_pkg::ROW_W-1:0]         out_index_o,
  output logic                              out_last_o
);

  localparam int unsigned ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned EXT_W  = (CNT_W > mvm_pkg::CCOUNT_W) ? CNT_W : mvm_pkg::CCOUNT_W;
  localparam int unsigned PROD_W = 2 * DATA_BITS;

  logic signed [DATA_BITS-1:0]       mem [MAX_COLUMNS];
  logic signed [DATA_BITS-1:0]       rdata_q;
  logic signed [DATA_BITS-1:0]       val_q;
  logic signed [PROD_W-1:0]          prod_q;
  logic signed [63:0]                prod_ext;
  logic [mvm_pkg::ACC_W-1:0]         acc_q, sum;

  logic [mvm_pkg::CCOUNT_W-1:0]      col_count_q;
  logic [mvm_pkg::ROW_W-1:0]         row_count_q;
  logic [ADDR_W-1:0]                 load_q, col_q, wr_ptr;
  logic [mvm_pkg::ROW_W-1:0]         row_q;

  logic [EXT_W-1:0]                  col_count_ext;
  logic [CNT_W-1:0]                  cols_eff, wr_inc, col_inc;
  logic [mvm_pkg::ROW_W:0]           rows_eff, row_inc;
  logic                              last_row;
  logic                              out_valid_q;

  always_comb begin
    col_count_ext = EXT_W'(col_count_q);
    if (col_count_q == '0) begin
      cols_eff = CNT_W'(1);
    end else if (col_count_ext > EXT_W'(MAX_COLUMNS)) begin
      cols_eff = CNT_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CNT_W'(col_count_q);
    end
    rows_eff = (row_count_q == '0) ? (mvm_pkg::ROW_W+1)'(1) : {1'b0, row_count_q};
  end

  assign wr_ptr   = (CNT_W'(load_q) >= cols_eff) ? '0 : load_q;
  assign wr_inc   = CNT_W'(wr_ptr) + CNT_W'(1);
  assign col_inc  = CNT_W'(col_q) + CNT_W'(1);
  assign row_inc  = {1'b0, row_q} + (mvm_pkg::ROW_W+1)'(1);
  assign last_row = (row_inc >= rows_eff);

  assign prod_ext = 64'(prod_q);
  assign sum      = acc_q + prod_ext[mvm_pkg::ACC_W-1:0];

  assign status_o.row_end  = (col_inc >= cols_eff);
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.vec_load) begin
      mem[wr_ptr] <= in_value_i;
    end
    if (cmd_i.mat_start) begin
      rdata_q <= mem[col_q];
      val_q   <= in_value_i;
    end
    if (cmd_i.mul) begin
      prod_q <= val_q * rdata_q;
    end
    if (cmd_i.acc && status_o.row_end) begin
      out_sum_o   <= sum;
      out_index_o <= row_q;
      out_last_o  <= last_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= mvm_pkg::COLUMN_COUNT_RST;
      row_count_q <= mvm_pkg::ROW_COUNT_RST;
      load_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          mvm_pkg::CFG_COLUMN_COUNT: col_count_q <= cfg_wdata_i[mvm_pkg::CCOUNT_W-1:0];
          mvm_pkg::CFG_ROW_COUNT:    row_count_q <= cfg_wdata_i[mvm_pkg::ROW_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.vec_load) begin
        load_q <= (wr_inc >= cols_eff) ? '0 : wr_inc[ADDR_W-1:0];
        col_q  <= '0;
        row_q  <= '0;
        acc_q  <= '0;
      end
      if (cmd_i.mat_start) begin
        load_q <= '0;
      end
      if (cmd_i.acc) begin
        if (status_o.row_end) begin
          acc_q       <= '0;
          col_q       <= '0;
          row_q       <= last_row ? '0 : row_inc[mvm_pkg::ROW_W-1:0];
          out_valid_q <= 1'b1;
        end else begin
          acc_q <= sum;
          col_q <= col_inc[ADDR_W-1:0];
        end
      end
    end
  end

endmodule

FILE: sv/matrix_vector_multiply_unit.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply_unit
// Dense matrix-vector product in signed fixed point, one row sum per row.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata: value; tuser: mode (0 vector, 1 matrix)
// m_axis    out        tdata: row_sum, row_index; tlast: last_row
// cfg       in         index 0 column_count, index 1 row_count
//
// A vector beat is stored on acceptance; the next is accepted right after it.
// A matrix beat goes through store read, multiply, accumulate, in that order.
// The accumulate step of a row-ending beat waits while the previous row sum
// is still unclaimed; other accumulate steps never wait.
// Reset clears counters and accumulator; the vector store is not cleared.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_unit #(
  parameter int unsigned MAX_COLUMNS = mvm_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned DATA_BITS   = mvm_pkg::DATA_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mvm_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((DATA_BITS+7)/8)*8-1:0]    s_axis_tdata,  // value
  input  logic                              s_axis_tuser,  // mode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mvm_pkg::OUT_W-1:0]         m_axis_tdata,  // row_sum, row_index
  output logic                              m_axis_tlast
);

  mvm_pkg::ctrl_cmd_t                cmd;
  mvm_pkg::dp_status_t               status;
  logic signed [mvm_pkg::ACC_W-1:0]  out_sum;
  logic [mvm_pkg::ROW_W-1:0]         out_index;

  mvm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mvm_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .DATA_BITS   (DATA_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_value_i  (s_axis_tdata[DATA_BITS-1:0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sum_o   (out_sum),
    .out_index_o (out_index),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_index, out_sum};

endmodule

FILE: sv/mvm_checker.sv
// ----------------------------------------------------------------------------
// mvm_checker
// Port-level checks of the matrix-vector multiply unit, bound to the top.
// ----------------------------------------------------------------------------
module mvm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       s_axis_tuser,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [mvm_pkg::OUT_W-1:0]  m_axis_tdata,
  input logic                       m_axis_tlast
);

  logic s_beat;

  assign s_beat = s_axis_tvalid && s_axis_tready;

  a_out_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Result beat withdrawn while stalled.");

  a_out_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("Result beat changed while stalled.");

  a_matrix_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat && (s_axis_tuser == mvm_pkg::MODE_MATRIX) |=> !s_axis_tready)
    else $error("Input accepted while a matrix beat is in progress.");

  a_matrix_two_cycles : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat && (s_axis_tuser == mvm_pkg::MODE_MATRIX) |=> ##1 !s_axis_tready)
    else $error("Matrix beat left the datapath before accumulating.");

  a_vector_single_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat && (s_axis_tuser == mvm_pkg::MODE_VECTOR) |=> s_axis_tready)
    else $error("Vector beat did not complete in one cycle.");

endmodule

bind matrix_vector_multiply_unit mvm_checker u_mvm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/matrix_vector_multiply_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_vector_multiply_unit_test
// Self-checking bench for the fixed-point matrix-vector multiply unit.
// Vector and matrix beats are streamed in with random gaps and the row sums
// are compared field by field against a cycle-free model of the product.
// Directed beats cover extreme values, dropped partial rows and zero counts.
// A full-width vector, counts lowered mid-row and a long output stall follow.
// Random phases with varied column and row counts close the run.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_unit_test;

  localparam int unsigned MAX_COLS       = mvm_pkg::MAX_COLUMNS_DEF;
  localparam int unsigned VALUE_W        = mvm_pkg::DATA_BITS_DEF;
  localparam int unsigned RANDOM_BEATS   = 600;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned STALL_CYCLES   = 400;

  typedef struct packed {
    logic               mode;
    logic [VALUE_W-1:0] value;
  } mvm_beat_t;

  typedef struct packed {
    logic [mvm_pkg::ACC_W-1:0] row_sum;
    logic [mvm_pkg::ROW_W-1:0] row_index;
    logic                      last_row;
  } rowsum_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [mvm_pkg::CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [mvm_pkg::CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [VALUE_W-1:0]             s_axis_tdata  = '0;
  logic                           s_axis_tuser  = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [mvm_pkg::OUT_W-1:0]      m_axis_tdata;
  logic                           m_axis_tlast;

  matrix_vector_multiply_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  mvm_beat_t   beat_queue[$];
  rowsum_t     rowsum_due[$];
  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned fail_count     = 0;
  int unsigned vector_beats   = 0;
  int unsigned matrix_beats   = 0;
  int unsigned rows_checked   = 0;
  int unsigned last_rows      = 0;
  int unsigned reg_writes     = 0;
  int unsigned quiet_cycles   = 0;
  bit          in_taken       = 1'b0;
  bit          out_taken      = 1'b0;
  bit          src_quiet      = 1'b0;
  bit          snk_quiet      = 1'b0;
  int unsigned send_gap       = 0;
  int unsigned sink_wait      = 0;
  int unsigned hold_left      = 0;

  // Product model: configuration copy and datapath state.
  logic [mvm_pkg::CCOUNT_W-1:0] col_cfg = mvm_pkg::COLUMN_COUNT_RST;
  logic [mvm_pkg::ROW_W-1:0]    row_cfg = mvm_pkg::ROW_COUNT_RST;
  logic signed [VALUE_W-1:0]    x_store [MAX_COLS];
  logic [mvm_pkg::CCOUNT_W-1:0] ld_ptr  = '0;
  logic [mvm_pkg::CCOUNT_W-1:0] col_pos = '0;
  logic [mvm_pkg::ROW_W-1:0]    row_pos = '0;
  logic [mvm_pkg::ACC_W-1:0]    acc     = '0;

  // Stimulus bookkeeping, so that no unwritten vector entry is ever read.
  bit          gen_written [MAX_COLS];
  int unsigned gen_cols = mvm_pkg::COLUMN_COUNT_RST;
  int unsigned gen_ptr  = 0;
  int unsigned gen_col  = 0;

  task automatic accumulate_beat(input mvm_beat_t b);
    int unsigned               ncols;
    int unsigned               nrows;
    int unsigned               p;
    logic signed [VALUE_W-1:0] v;
    logic signed [VALUE_W-1:0] x;
    logic signed [31:0]        prod;
    rowsum_t                   r;
    ncols = (col_cfg == 0) ? 1 : ((col_cfg > MAX_COLS) ? MAX_COLS : col_cfg);
    nrows = (row_cfg == 0) ? 1 : row_cfg;
    v = b.value;
    if (b.mode == mvm_pkg::MODE_VECTOR) begin
      p = (ld_ptr >= ncols) ? 0 : ld_ptr;
      x_store[p] = v;
      p++;
      ld_ptr = (p >= ncols) ? '0 : mvm_pkg::CCOUNT_W'(p);
      row_pos = '0;
      col_pos = '0;
      acc = '0;
      vector_beats++;
    end else begin
      ld_ptr = '0;
      x = x_store[(col_pos >= MAX_COLS) ? 0 : col_pos];
      prod = v * x;
      acc = acc + {{(mvm_pkg::ACC_W-32){prod[31]}}, prod};
      if (col_pos + 1 >= ncols) begin
        r.row_sum = acc;
        r.row_index = row_pos;
        r.last_row = (row_pos + 1 >= nrows);
        rowsum_due.push_back(r);
        acc = '0;
        col_pos = '0;
        row_pos = r.last_row ? '0 : row_pos + 1'b1;
      end else begin
        col_pos++;
      end
      matrix_beats++;
    end
  endtask

  always @(posedge clk_i) begin
    rowsum_t   want;
    mvm_beat_t seen;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          mvm_pkg::CFG_COLUMN_COUNT: col_cfg = cfg_wdata_i[mvm_pkg::CCOUNT_W-1:0];
          mvm_pkg::CFG_ROW_COUNT:    row_cfg = cfg_wdata_i[mvm_pkg::ROW_W-1:0];
          default: ;
        endcase
      end
      in_taken <= s_axis_tvalid && s_axis_tready;
      out_taken <= m_axis_tvalid && m_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        seen.mode = s_axis_tuser;
        seen.value = s_axis_tdata;
        accumulate_beat(seen);
        accepted_count++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (rowsum_due.size() == 0) begin
          $error("Row sum beat with no row pending: row_sum=%0d row_index=%0d",
                 $signed(m_axis_tdata[mvm_pkg::ACC_W-1:0]),
                 m_axis_tdata[mvm_pkg::OUT_W-1:mvm_pkg::ACC_W]);
          fail_count++;
        end else begin
          want = rowsum_due.pop_front();
          if (m_axis_tdata[mvm_pkg::ACC_W-1:0] !== want.row_sum) begin
            $error("row_sum: expected %0d, got %0d", $signed(want.row_sum),
                   $signed(m_axis_tdata[mvm_pkg::ACC_W-1:0]));
            fail_count++;
          end
          if (m_axis_tdata[mvm_pkg::OUT_W-1:mvm_pkg::ACC_W] !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index,
                   m_axis_tdata[mvm_pkg::OUT_W-1:mvm_pkg::ACC_W]);
            fail_count++;
          end
          if (m_axis_tlast !== want.last_row) begin
            $error("last_row: expected %0d, got %0d", want.last_row, m_axis_tlast);
            fail_count++;
          end
          rows_checked++;
          if (want.last_row) last_rows++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("[matrix_vector_multiply_unit] ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    mvm_beat_t nxt;
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (send_gap > 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap--;
        end else if (beat_queue.size() != 0) begin
          nxt = beat_queue.pop_front();
          s_axis_tuser <= nxt.mode;
          s_axis_tdata <= nxt.value;
          s_axis_tvalid <= 1'b1;
          send_gap = src_quiet ? 0 : $urandom_range(0, 7);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) sink_wait = snk_quiet ? 0 : $urandom_range(0, 7);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic bit vector_ready();
    for (int unsigned i = 0; i < gen_cols; i++) begin
      if (!gen_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic push_beat(input logic mode, input logic [VALUE_W-1:0] value);
    mvm_beat_t   b;
    int unsigned p;
    b.mode = mode;
    b.value = value;
    if (b.mode == mvm_pkg::MODE_MATRIX && !gen_written[gen_col]) begin
      b.mode = mvm_pkg::MODE_VECTOR;
    end
    if (b.mode == mvm_pkg::MODE_VECTOR) begin
      p = (gen_ptr >= gen_cols) ? 0 : gen_ptr;
      gen_written[p] = 1'b1;
      p++;
      gen_ptr = (p >= gen_cols) ? 0 : p;
      gen_col = 0;
    end else begin
      gen_ptr = 0;
      gen_col = (gen_col + 1 >= gen_cols) ? 0 : gen_col + 1;
    end
    beat_queue.push_back(b);
    queued_count++;
  endtask

  task automatic load_vector();
    repeat (gen_cols) push_beat(mvm_pkg::MODE_VECTOR, pick_value());
  endtask

  task automatic write_reg(input logic [mvm_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [mvm_pkg::CFG_DATA_W-1:0] data);
    logic [mvm_pkg::CCOUNT_W-1:0] c;
    while (accepted_count != queued_count || rowsum_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == mvm_pkg::CFG_COLUMN_COUNT) begin
      c = data[mvm_pkg::CCOUNT_W-1:0];
      gen_cols = (c == 0) ? 1 : ((c > MAX_COLS) ? MAX_COLS : c);
    end
    reg_writes++;
  endtask

  initial begin
    int unsigned                    random_start;
    int unsigned                    cols;
    int unsigned                    rows;
    int unsigned                    n;
    logic [mvm_pkg::CFG_DATA_W-1:0] col_word;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(mvm_pkg::CFG_COLUMN_COUNT, 16'd3);
    write_reg(mvm_pkg::CFG_ROW_COUNT, 16'd2);
    push_beat(mvm_pkg::MODE_VECTOR, 16'h8000);
    push_beat(mvm_pkg::MODE_VECTOR, 16'h7FFF);
    push_beat(mvm_pkg::MODE_VECTOR, 16'h0001);
    push_beat(mvm_pkg::MODE_MATRIX, 16'h8000);
    push_beat(mvm_pkg::MODE_MATRIX, 16'h7FFF);
    push_beat(mvm_pkg::MODE_MATRIX, 16'hFFFF);
    push_beat(mvm_pkg::MODE_MATRIX, 16'h7FFF);
    push_beat(mvm_pkg::MODE_MATRIX, 16'h8000);
    push_beat(mvm_pkg::MODE_MATRIX, 16'h0000);
    // A partial row is dropped by the vector beat that follows it.
    push_beat(mvm_pkg::MODE_MATRIX, 16'h1234);
    push_beat(mvm_pkg::MODE_VECTOR, 16'h4000);
    push_beat(mvm_pkg::MODE_MATRIX, 16'h0100);
    push_beat(mvm_pkg::MODE_MATRIX, 16'h0200);
    push_beat(mvm_pkg::MODE_MATRIX, 16'h0300);
    // Zero counts act as one: every matrix beat is a whole, final row.
    write_reg(mvm_pkg::CFG_COLUMN_COUNT, 16'd0);
    write_reg(mvm_pkg::CFG_ROW_COUNT, 16'd0);
    push_beat(mvm_pkg::MODE_MATRIX, 16'h7FFF);
    push_beat(mvm_pkg::MODE_MATRIX, 16'h8000);
    push_beat(mvm_pkg::MODE_VECTOR, 16'h0001);
    push_beat(mvm_pkg::MODE_MATRIX, 16'hFFFF);

    // An oversized column count saturates; fill the whole store once and
    // let one more vector beat wrap around to the first entry.
    src_quiet = 1'b1;
    write_reg(mvm_pkg::CFG_COLUMN_COUNT, 16'd2047);
    write_reg(mvm_pkg::CFG_ROW_COUNT, 16'd1);
    load_vector();
    push_beat(mvm_pkg::MODE_VECTOR, pick_value());
    src_quiet = 1'b0;

    // Stop mid-row at full width, then lower the column count under it.
    write_reg(mvm_pkg::CFG_COLUMN_COUNT, 16'd1024);
    write_reg(mvm_pkg::CFG_ROW_COUNT, 16'd65535);
    repeat (40) push_beat(mvm_pkg::MODE_MATRIX, pick_value());
    write_reg(mvm_pkg::CFG_COLUMN_COUNT, 16'd5);
    repeat (12) push_beat(mvm_pkg::MODE_MATRIX, pick_value());

    // Output held off while single-column rows keep arriving.
    write_reg(mvm_pkg::CFG_COLUMN_COUNT, 16'd1);
    write_reg(mvm_pkg::CFG_ROW_COUNT, 16'd4);
    load_vector();
    src_quiet = 1'b1;
    @(posedge clk_i);
    hold_left = STALL_CYCLES;
    repeat (80) push_beat(mvm_pkg::MODE_MATRIX, pick_value());
    while (hold_left > 0) @(negedge clk_i);
    src_quiet = 1'b0;

    random_start = queued_count;
    while (queued_count - random_start < RANDOM_BEATS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: cols = $urandom_range(1, 8);
        6, 7:             cols = $urandom_range(9, 40);
        8:                cols = 0;
        default:          cols = $urandom_range(1, 16);
      endcase
      col_word = mvm_pkg::CFG_DATA_W'(cols);
      if ($urandom_range(0, 4) == 0) begin
        col_word[mvm_pkg::CFG_DATA_W-1:mvm_pkg::CCOUNT_W] =
          (mvm_pkg::CFG_DATA_W-mvm_pkg::CCOUNT_W)'($urandom);
      end
      case ($urandom_range(0, 9))
        0:       rows = 0;
        1:       rows = 1;
        2:       rows = 65535;
        default: rows = $urandom_range(2, 5);
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(mvm_pkg::CFG_COLUMN_COUNT, col_word);
        1: write_reg(mvm_pkg::CFG_ROW_COUNT, mvm_pkg::CFG_DATA_W'(rows));
        default: begin
          write_reg(mvm_pkg::CFG_COLUMN_COUNT, col_word);
          write_reg(mvm_pkg::CFG_ROW_COUNT, mvm_pkg::CFG_DATA_W'(rows));
        end
      endcase
      src_quiet = ($urandom_range(0, 3) == 0);
      snk_quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        if (!vector_ready() || $urandom_range(0, 2) == 0) load_vector();
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 3)) push_beat(1'($urandom), pick_value());
        end
        n = $urandom_range(1, 4) * gen_cols;
        if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
        repeat (n) push_beat(mvm_pkg::MODE_MATRIX, pick_value());
      end
    end

    while (accepted_count != queued_count || rowsum_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Run covered %0d vector beats and %0d matrix beats over %0d register writes.",
             vector_beats, matrix_beats, reg_writes);
    $display("Checked %0d row sums, %0d of them final rows; %0d mismatches.",
             rows_checked, last_rows, fail_count);
    if (fail_count == 0 && rowsum_due.size() == 0) begin
      $display("[matrix_vector_multiply_unit] OK");
    end else begin
      $display("[matrix_vector_multiply_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: matrix_vector_multiply_unit.f
sv/mvm_pkg.sv
sv/mvm_ctrl.sv
sv/mvm_datapath.sv
sv/matrix_vector_multiply_unit.sv
sv/mvm_checker.sv
tb/matrix_vector_multiply_unit_test.sv
